// ----- rtl/hbs_pkg.sv -----
`default_nettype none
package hbs_pkg;

  // Longest run of ones allowed before a zero is inserted.
  localparam int unsigned STUFF_RUN  = 5;
  // One input byte grows to at most ten bits after stuffing.
  localparam int unsigned STUFF_W    = 10;
  // Accumulator: up to seven held bits plus one stuffed byte.
  localparam int unsigned ACC_W      = 17;
  localparam int unsigned ACC_CNT_W  = 5;
  // Queue between the stuffing front and the packing back.
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = 2;
  localparam int unsigned QCNT_W     = 3;

  localparam logic [3:0] FULL_BYTE_BITS = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] valid_bits;
    logic [9:0] out_index;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic [STUFF_W-1:0] bits;
    logic [3:0]         nbits;
    logic [2:0]         run;
  } stuff_t;

  typedef struct packed {
    logic [STUFF_W-1:0] bits;
    logic [3:0]         nbits;
    logic               last;
  } entry_t;

  // Walk one byte LSB first, inserting a zero after each run of five ones.
  function automatic stuff_t stuff_byte(input logic [7:0] data, input logic [2:0] run_in);
    stuff_t     res;
    logic [3:0] pos;
    logic [2:0] r;
    res.bits = '0;
    pos = '0;
    r = run_in;
    for (int i = 0; i < 8; i++) begin
      res.bits[pos] = data[i];
      pos = pos + 4'd1;
      if (data[i]) begin
        if (r == 3'(STUFF_RUN - 1)) begin
          r = '0;
          pos = pos + 4'd1;   // stuffed zero is already in place
        end else begin
          r = r + 3'd1;
        end
      end else begin
        r = '0;
      end
    end
    res.nbits = pos;
    res.run = r;
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/hbs_front.sv -----
`default_nettype none
module hbs_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               byte_valid,
  output logic              byte_ready,
  input  hbs_pkg::in_item_t byte_item,
  output logic              push,
  input  wire               push_ready,
  output hbs_pkg::entry_t   push_entry
);

  logic [2:0]      ones_run;
  logic [2:0]      ones_run_next;
  hbs_pkg::stuff_t st;

  always_comb begin
    st = hbs_pkg::stuff_byte(byte_item.data_byte, ones_run);
    byte_ready = push_ready;
    push = byte_valid && push_ready;
    push_entry.bits = st.bits;
    push_entry.nbits = st.nbits;
    push_entry.last = byte_item.frame_end;
    ones_run_next = ones_run;
    if (push) begin
      // a new frame starts with a clean run count
      ones_run_next = byte_item.frame_end ? 3'd0 : st.run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ones_run <= '0;
    end else begin
      ones_run <= ones_run_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hbs_queue.sv -----
`default_nettype none
module hbs_queue (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  output logic            push_ready,
  input  hbs_pkg::entry_t push_entry,
  output logic            pop_valid,
  input  wire             pop,
  output hbs_pkg::entry_t pop_entry
);

  hbs_pkg::entry_t                 mem [hbs_pkg::QDEPTH];
  logic [hbs_pkg::QPTR_W-1:0]      wr_ptr;
  logic [hbs_pkg::QPTR_W-1:0]      rd_ptr;
  logic [hbs_pkg::QCNT_W-1:0]      fill;
  logic [hbs_pkg::QPTR_W-1:0]      wr_ptr_next;
  logic [hbs_pkg::QPTR_W-1:0]      rd_ptr_next;
  logic [hbs_pkg::QCNT_W-1:0]      fill_next;

  always_comb begin
    push_ready = (fill != hbs_pkg::QCNT_W'(hbs_pkg::QDEPTH));
    pop_valid = (fill != '0);
    pop_entry = mem[rd_ptr];
    wr_ptr_next = push ? wr_ptr + 1'b1 : wr_ptr;
    rd_ptr_next = pop ? rd_ptr + 1'b1 : rd_ptr;
    fill_next = fill;
    if (push && !pop) begin
      fill_next = fill + 1'b1;
    end else if (pop && !push) begin
      fill_next = fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      fill <= fill_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hbs_back.sv -----
`default_nettype none
module hbs_back #(
  parameter int unsigned MAX_OUT_BYTES = 512
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                pop_valid,
  output logic               pop,
  input  hbs_pkg::entry_t    pop_entry,
  output logic               result_valid,
  input  wire                result_ready,
  output hbs_pkg::out_item_t result_item
);

  localparam int unsigned CNT_W = $clog2(MAX_OUT_BYTES + 1);

  logic [hbs_pkg::ACC_W-1:0]     acc, acc_next, acc_p;
  logic [hbs_pkg::ACC_CNT_W-1:0] cnt, cnt_next, cnt_p;
  logic                          last, last_next;
  logic                          busy, busy_next;
  logic [CNT_W-1:0]              bcount, bcount_next, bcount_inc;
  logic                          result_valid_next;
  hbs_pkg::out_item_t            result_item_next;
  logic                          need_full, need_part, out_free, emit, stall;
  logic                          remaining, done;

  always_comb begin
    out_free = !result_valid || result_ready;
    need_full = busy && (cnt >= hbs_pkg::ACC_CNT_W'(8));
    need_part = busy && last && (cnt != '0) && (cnt < hbs_pkg::ACC_CNT_W'(8));
    emit = (need_full || need_part) && out_free;
    stall = (need_full || need_part) && !out_free;
    bcount_inc = (bcount < CNT_W'(MAX_OUT_BYTES)) ? bcount + 1'b1 : bcount;

    acc_p = acc;
    cnt_p = cnt;
    bcount_next = bcount;
    if (emit) begin
      bcount_next = bcount_inc;
      if (need_full) begin
        acc_p = acc >> 8;
        cnt_p = cnt - hbs_pkg::ACC_CNT_W'(8);
      end else begin
        acc_p = '0;
        cnt_p = '0;
      end
    end

    remaining = (cnt_p >= hbs_pkg::ACC_CNT_W'(8)) || (last && (cnt_p != '0));
    done = !busy || (!stall && !remaining);
    if (done && busy && last) begin
      acc_p = '0;
      cnt_p = '0;
      bcount_next = '0;
    end

    pop = done && pop_valid;
    acc_next = acc_p;
    cnt_next = cnt_p;
    last_next = last;
    busy_next = busy;
    if (pop) begin
      acc_next = acc_p | (hbs_pkg::ACC_W'(pop_entry.bits) << cnt_p);
      cnt_next = cnt_p + hbs_pkg::ACC_CNT_W'(pop_entry.nbits);
      last_next = pop_entry.last;
      busy_next = 1'b1;
    end else if (done) begin
      busy_next = 1'b0;
    end
  end

  always_comb begin
    result_valid_next = emit ? 1'b1 : (result_ready ? 1'b0 : result_valid);
    result_item_next = result_item;
    if (emit) begin
      result_item_next.out_byte = acc[7:0];
      result_item_next.valid_bits = need_full ? hbs_pkg::FULL_BYTE_BITS : cnt[3:0];
      result_item_next.out_index = 10'(bcount_inc);
      result_item_next.frame_last = need_full ? (last && (cnt == hbs_pkg::ACC_CNT_W'(8)))
                                              : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    result_item <= result_item_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
      last <= 1'b0;
      busy <= 1'b0;
      bcount <= '0;
      result_valid <= 1'b0;
    end else begin
      acc <= acc_next;
      cnt <= cnt_next;
      last <= last_next;
      busy <= busy_next;
      bcount <= bcount_next;
      result_valid <= result_valid_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hdlc_bit_stuffer_lsb_first.sv -----
// HDLC bit stuffer, least significant bit first.
//
// Input channel (byte_valid / byte_ready / byte_item): one frame byte per
// transfer, with frame_end set on the frame's last byte. Output channel
// (result_valid / result_ready / result_item): stuffed bytes packed LSB
// first, each with its count of valid bits, running index in the frame,
// and frame_last on the frame's final byte.
//
// An input byte passes the queue entry, the packer accumulator and the
// output register before its first result appears. The packer issues
// one output byte per cycle while the receiver takes them, and takes the
// next queued byte in the cycle it issues the last byte of the current
// one; the four-entry queue lets the front keep taking bytes one per
// cycle, while the queue has room, as the packer drains.
//
// Reset clears the run count, the queue, the packer and the output
// valid flag. When the receiver stalls, the output register holds its
// result, the packer stops, the queue fills, and byte_ready drops.
`default_nettype none
module hdlc_bit_stuffer_lsb_first #(
  parameter int unsigned MAX_OUT_BYTES = 512
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                byte_valid,
  output logic               byte_ready,
  input  hbs_pkg::in_item_t  byte_item,
  output logic               result_valid,
  input  wire                result_ready,
  output hbs_pkg::out_item_t result_item
);

  logic            push, push_ready, pop_valid, pop;
  hbs_pkg::entry_t push_entry, pop_entry;

  // Front: stuff each byte and track the run of ones.
  hbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .push       (push),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // Queue: decouple stuffing from packing.
  hbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_entry  (pop_entry)
  );

  // Back: pack stuffed bits into bytes, flush at frame end, count bytes.
  hbs_back #(
    .MAX_OUT_BYTES (MAX_OUT_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop          (pop),
    .pop_entry    (pop_entry),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  // A partial byte only ever closes a frame.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_item.valid_bits != hbs_pkg::FULL_BYTE_BITS)
      |-> result_item.frame_last)
    else $error("partial byte without frame_last");

  // Valid bit count stays in 1..8 and the index is never zero.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_item.valid_bits != 4'd0) &&
                     (result_item.valid_bits <= hbs_pkg::FULL_BYTE_BITS) &&
                     (result_item.out_index != 10'd0))
    else $error("result fields out of range");

  // A stuffed byte always carries eight to ten bits.
  assert property (@(posedge clk) disable iff (rst)
    push |-> (push_entry.nbits >= 4'd8) && (push_entry.nbits <= 4'(hbs_pkg::STUFF_W)))
    else $error("stuffed length out of range");

endmodule
`default_nettype wire
